// ----- rtl/tt3_pkg.sv -----
// Shared types and constants of the three-channel timed toggle sequencer.
package tt3_pkg;

  localparam int unsigned NUM_CH = 3;
  localparam logic PIN_LOW = 1'b0;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_LENGTH = 3'd2,
    CMD_ARM    = 3'd3,
    CMD_REWIND = 3'd4
  } cmd_e;

  localparam logic [1:0] CH_HEAD  = 2'd0;
  localparam logic [1:0] CH_TAIL  = 2'd1;
  localparam logic [1:0] CH_MOUTH = 2'd2;

  typedef struct packed {
    logic head_level;
    logic tail_level;
    logic mouth_level;
    logic waiting;
    logic running;
  } result_t;

endpackage

// ----- rtl/tt3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tt3_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/timed_toggle_sequencer_3ch.sv -----
// Three-channel timed toggle sequencer: timestamp tables in RAM, toggle and interlock logic.
// Output: the result of a request is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one request per cycle while in_stall_o is low, set by the lookahead read of each channel's table RAM,
//   which always presents the entry at the channel's next position.
// Reset: positions, lengths, flags, pins and start stamp clear, waiting is set;
//   the table RAMs hold no reset and read undefined until written.
module timed_toggle_sequencer_3ch #(
  parameter int MAX_STEPS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [1:0]  channel_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] entry_value_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        head_level_o,
  output logic        tail_level_o,
  output logic        mouth_level_o,
  output logic        waiting_o,
  output logic        running_o
);

  // Address bits of a table and bits of a position, which may reach MAX_STEPS itself.
  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int PW = $clog2(MAX_STEPS + 1);
  localparam int NC = tt3_pkg::NUM_CH;

  // Channel state in flip-flops; the timestamp tables live in the RAMs.
  logic [PW-1:0] pos_q [NC];
  logic [PW-1:0] pos_d [NC];
  logic [PW-1:0] len_q [NC];
  logic [PW-1:0] len_d [NC];
  logic [NC-1:0] flag_q, flag_d;
  logic [NC-1:0] pin_q, pin_d;
  logic [31:0]   start_q, start_d;
  logic          started_q, started_d;
  logic          idle_q, idle_d;

  // Output register plus one skid entry so a request is taken while a result waits.
  tt3_pkg::result_t out_q, skid_q, res_d;
  logic             out_valid_q, skid_valid_q;

  logic accept;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;

  // Table write decode: drop bad channels and slots past the table depth.
  logic [31:0]   idx_wide;
  logic [AW-1:0] waddr;
  logic          slot_ok;
  logic [NC-1:0] we;

  assign idx_wide = 32'(entry_index_i);
  assign waddr    = idx_wide[AW-1:0];
  assign slot_ok  = idx_wide < 32'(MAX_STEPS);

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      we[c] = accept && (tt3_pkg::cmd_e'(cmd_i) == tt3_pkg::CMD_WRITE) && slot_ok &&
              (channel_i == 2'(c));
    end
  end

  // Each RAM reads the position that the channel will hold next, so the entry for the
  // current position is ready in the cycle a tick arrives. A write landing on that same
  // address is forwarded around the RAM.
  logic [31:0]   rdata [NC];
  logic [31:0]   tbl   [NC];
  logic [NC-1:0] fwd_hit_q;
  logic [31:0]   fwd_data_q;

  for (genvar g = 0; g < NC; g++) begin : g_tbl
    logic [AW-1:0] raddr;
    assign raddr = pos_d[g][AW-1:0];

    tt3_ram #(
      .WIDTH (32),
      .DEPTH (MAX_STEPS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[g]),
      .waddr_i (waddr),
      .wdata_i (entry_value_i),
      .raddr_i (raddr),
      .rdata_o (rdata[g])
    );

    assign tbl[g] = fwd_hit_q[g] ? fwd_data_q : rdata[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= '0;
    end else begin
      for (int c = 0; c < NC; c++) begin
        fwd_hit_q[c] <= we[c] && (waddr == pos_d[c][AW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= entry_value_i;
  end

  // Per-request state update.
  logic [31:0]   elapsed;
  logic [NC-1:0] due;
  logic [NC-1:0] flag_tog;
  logic [PW-1:0] len_sat;
  logic          done;

  assign elapsed  = now_ms_i - start_q;
  assign flag_tog = flag_q ^ due;
  assign len_sat  = (entry_value_i > 32'(MAX_STEPS)) ? PW'(MAX_STEPS) : entry_value_i[PW-1:0];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      due[c] = (pos_q[c] < len_q[c]) && (elapsed >= tbl[c]);
    end
  end

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    flag_d    = flag_q;
    pin_d     = pin_q;
    start_d   = start_q;
    started_d = started_q;
    idle_d    = idle_q;
    done      = 1'b1;

    if (accept) begin
      case (tt3_pkg::cmd_e'(cmd_i))
        tt3_pkg::CMD_TICK: begin
          if (!idle_q) begin
            if (!started_q) begin
              // Latch the start time only; no compare on this tick.
              start_d   = now_ms_i;
              started_d = 1'b1;
            end else begin
              flag_d = flag_tog;
              for (int c = 0; c < NC; c++) begin
                if (due[c]) begin
                  pos_d[c] = pos_q[c] + PW'(1);
                end
              end
              // Head and tail interlock; tail is checked first and wins.
              if (due[tt3_pkg::CH_TAIL]) begin
                pin_d[tt3_pkg::CH_HEAD] = tt3_pkg::PIN_LOW;
                pin_d[tt3_pkg::CH_TAIL] = flag_tog[tt3_pkg::CH_TAIL];
              end else if (due[tt3_pkg::CH_HEAD]) begin
                pin_d[tt3_pkg::CH_HEAD] = flag_tog[tt3_pkg::CH_HEAD];
                pin_d[tt3_pkg::CH_TAIL] = tt3_pkg::PIN_LOW;
              end
              if (due[tt3_pkg::CH_MOUTH]) begin
                pin_d[tt3_pkg::CH_MOUTH] = flag_tog[tt3_pkg::CH_MOUTH];
              end
              for (int c = 0; c < NC; c++) begin
                if (pos_d[c] < len_q[c]) begin
                  done = 1'b0;
                end
              end
              // All channels exhausted: drop back to waiting for arm.
              if (done) begin
                started_d = 1'b0;
                idle_d    = 1'b1;
              end
            end
          end
        end
        tt3_pkg::CMD_LENGTH: begin
          for (int c = 0; c < NC; c++) begin
            if (channel_i == 2'(c)) begin
              len_d[c] = len_sat;
            end
          end
        end
        tt3_pkg::CMD_ARM: begin
          idle_d = 1'b0;
        end
        tt3_pkg::CMD_REWIND: begin
          for (int c = 0; c < NC; c++) begin
            pos_d[c] = '0;
          end
          started_d = 1'b0;
        end
        default: begin
          // Table writes go straight to the RAMs; unused codes report current levels.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NC; c++) begin
        pos_q[c] <= '0;
        len_q[c] <= '0;
      end
      flag_q    <= '0;
      pin_q     <= '0;
      start_q   <= '0;
      started_q <= 1'b0;
      idle_q    <= 1'b1;
    end else begin
      pos_q     <= pos_d;
      len_q     <= len_d;
      flag_q    <= flag_d;
      pin_q     <= pin_d;
      start_q   <= start_d;
      started_q <= started_d;
      idle_q    <= idle_d;
    end
  end

  // Result of this request: the state after it.
  always_comb begin
    res_d.head_level  = pin_d[tt3_pkg::CH_HEAD];
    res_d.tail_level  = pin_d[tt3_pkg::CH_TAIL];
    res_d.mouth_level = pin_d[tt3_pkg::CH_MOUTH];
    res_d.waiting     = idle_d;
    res_d.running     = started_d;
  end

  // Output register and skid: the skid fills only when the output is held by a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign head_level_o  = out_q.head_level;
  assign tail_level_o  = out_q.tail_level;
  assign mouth_level_o = out_q.mouth_level;
  assign waiting_o     = out_q.waiting;
  assign running_o     = out_q.running;

endmodule
